@@ hw/rtl/bpt_pkg.sv @@
// shared constants and types for the barycentric point-in-triangle pipeline
// no dependencies
package bpt_pkg;

   localparam int COORD_BITS_DEF       = 16;
   localparam int WEIGHT_FRAC_BITS_DEF = 16;

   // number of register stages in the geometry front end
   localparam int GEOM_STAGES = 7;

   typedef struct packed {
      logic in_tri;
      logic degen;
      logic neg_u;
      logic neg_v;
      logic neg_w;
   } bpt_flags_type;

endpackage

@@ hw/rtl/bpt_geom.sv @@
// geometry front end: normal, plane choice, projected sub-areas, magnitudes and flags
// depends on bpt_pkg
module bpt_geom import bpt_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic signed [COORD_BITS-1:0] ax,
   input  logic signed [COORD_BITS-1:0] ay,
   input  logic signed [COORD_BITS-1:0] az,
   input  logic signed [COORD_BITS-1:0] bx,
   input  logic signed [COORD_BITS-1:0] by_coord,
   input  logic signed [COORD_BITS-1:0] bz,
   input  logic signed [COORD_BITS-1:0] cx,
   input  logic signed [COORD_BITS-1:0] cy,
   input  logic signed [COORD_BITS-1:0] cz,
   input  logic signed [COORD_BITS-1:0] px,
   input  logic signed [COORD_BITS-1:0] py,
   input  logic signed [COORD_BITS-1:0] pz,
   output logic                         out_valid,
   output bpt_flags_type                out_flags,
   output logic [2*COORD_BITS+6:0]      out_nmag_u,
   output logic [2*COORD_BITS+6:0]      out_nmag_v,
   output logic [2*COORD_BITS+6:0]      out_nmag_w,
   output logic [2*COORD_BITS+6:0]      out_dmag
);
   localparam int CB = COORD_BITS;
   localparam int EW = CB + 1;
   localparam int PW = 2 * EW;
   localparam int MW = PW + 1;
   localparam int DW = MW + 1;
   localparam int NW = MW + 4;

   logic [GEOM_STAGES-1:0] v_ff, v_in;

   // stage 1: edges
   logic signed [CB-1:0] a1_ff [3], b1_ff [3], c1_ff [3], p1_ff [3];
   logic signed [EW-1:0] e1_ff [3], e2_ff [3];
   // stage 2: cross product terms
   logic signed [CB-1:0] a2_ff [3], b2_ff [3], c2_ff [3], p2_ff [3];
   logic signed [PW-1:0] pr_ff [6];
   // stage 3: normal
   logic signed [CB-1:0] a3_ff [3], b3_ff [3], c3_ff [3], p3_ff [3];
   logic signed [MW-1:0] m3_ff [3];
   // stage 4: plane select and area operands
   logic signed [EW-1:0] d4_ff [8], d4_in [8];
   logic signed [DW-1:0] den4_ff, den4_in;
   // stage 5: area products
   logic signed [PW-1:0] ap5_ff [4];
   logic signed [DW-1:0] den5_ff;
   // stage 6: sub-areas
   logic signed [MW-1:0] nu6_ff, nv6_ff;
   logic signed [DW-1:0] den6_ff;
   // stage 7: magnitudes and flags
   logic [NW-1:0]        nmu_ff, nmv_ff, nmw_ff, dm_ff;
   bpt_flags_type        flags_ff, flags_in;
   logic [NW-1:0]        nmu_in, nmv_in, nmw_in, dm_in;

   logic signed [CB-1:0] a_in [3], b_in [3], c_in [3], p_in [3];
   logic [MW-1:0]        mx, my, mz;
   logic signed [CB-1:0] ps, pt, as_c, at_c, bs, bt, cs, ct;
   logic signed [NW-1:0] nu_x, nv_x, nw_x, den_x;

   assign v_in = {v_ff[GEOM_STAGES-2:0], in_valid};

   always_comb begin
      a_in = '{ax, ay, az};
      b_in = '{bx, by_coord, bz};
      c_in = '{cx, cy, cz};
      p_in = '{px, py, pz};
   end

   // plane choice: drop the largest normal axis, ties to x then y
   always_comb begin
      mx = m3_ff[0][MW-1] ? MW'(-m3_ff[0]) : MW'(m3_ff[0]);
      my = m3_ff[1][MW-1] ? MW'(-m3_ff[1]) : MW'(m3_ff[1]);
      mz = m3_ff[2][MW-1] ? MW'(-m3_ff[2]) : MW'(m3_ff[2]);
      if (mx >= my && mx >= mz) begin
         ps = p3_ff[1]; pt = p3_ff[2];
         as_c = a3_ff[1]; at_c = a3_ff[2];
         bs = b3_ff[1]; bt = b3_ff[2];
         cs = c3_ff[1]; ct = c3_ff[2];
         den4_in = DW'(m3_ff[0]);
      end else if (my >= mz) begin
         ps = p3_ff[0]; pt = p3_ff[2];
         as_c = a3_ff[0]; at_c = a3_ff[2];
         bs = b3_ff[0]; bt = b3_ff[2];
         cs = c3_ff[0]; ct = c3_ff[2];
         den4_in = -DW'(m3_ff[1]);
      end else begin
         ps = p3_ff[0]; pt = p3_ff[1];
         as_c = a3_ff[0]; at_c = a3_ff[1];
         bs = b3_ff[0]; bt = b3_ff[1];
         cs = c3_ff[0]; ct = c3_ff[1];
         den4_in = DW'(m3_ff[2]);
      end
      // area(p,b,c) operands
      d4_in[0] = EW'(ps) - EW'(bs);
      d4_in[1] = EW'(bt) - EW'(ct);
      d4_in[2] = EW'(bs) - EW'(cs);
      d4_in[3] = EW'(pt) - EW'(bt);
      // area(p,c,a) operands
      d4_in[4] = EW'(ps) - EW'(cs);
      d4_in[5] = EW'(ct) - EW'(at_c);
      d4_in[6] = EW'(cs) - EW'(as_c);
      d4_in[7] = EW'(pt) - EW'(ct);
   end

   always_comb begin
      nu_x  = NW'(nu6_ff);
      nv_x  = NW'(nv6_ff);
      den_x = NW'(den6_ff);
      nw_x  = den_x - nu_x - nv_x;
      nmu_in = nu_x[NW-1] ? NW'(-nu_x) : NW'(nu_x);
      nmv_in = nv_x[NW-1] ? NW'(-nv_x) : NW'(nv_x);
      nmw_in = nw_x[NW-1] ? NW'(-nw_x) : NW'(nw_x);
      dm_in  = den_x[NW-1] ? NW'(-den_x) : NW'(den_x);
      flags_in.degen  = (den_x == '0);
      flags_in.neg_u  = nu_x[NW-1] != den_x[NW-1];
      flags_in.neg_v  = nv_x[NW-1] != den_x[NW-1];
      flags_in.neg_w  = nw_x[NW-1] != den_x[NW-1];
      flags_in.in_tri = !flags_in.degen
         && (nu_x == '0 || !flags_in.neg_u)
         && (nv_x == '0 || !flags_in.neg_v)
         && (nw_x == '0 || !flags_in.neg_w);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         a1_ff[i] <= a_in[i];
         b1_ff[i] <= b_in[i];
         c1_ff[i] <= c_in[i];
         p1_ff[i] <= p_in[i];
         e1_ff[i] <= EW'(b_in[i]) - EW'(a_in[i]);
         e2_ff[i] <= EW'(c_in[i]) - EW'(a_in[i]);
         a2_ff[i] <= a1_ff[i];
         b2_ff[i] <= b1_ff[i];
         c2_ff[i] <= c1_ff[i];
         p2_ff[i] <= p1_ff[i];
         a3_ff[i] <= a2_ff[i];
         b3_ff[i] <= b2_ff[i];
         c3_ff[i] <= c2_ff[i];
         p3_ff[i] <= p2_ff[i];
      end
      pr_ff[0] <= PW'(e1_ff[1]) * PW'(e2_ff[2]);
      pr_ff[1] <= PW'(e1_ff[2]) * PW'(e2_ff[1]);
      pr_ff[2] <= PW'(e1_ff[2]) * PW'(e2_ff[0]);
      pr_ff[3] <= PW'(e1_ff[0]) * PW'(e2_ff[2]);
      pr_ff[4] <= PW'(e1_ff[0]) * PW'(e2_ff[1]);
      pr_ff[5] <= PW'(e1_ff[1]) * PW'(e2_ff[0]);
      m3_ff[0] <= MW'(pr_ff[0]) - MW'(pr_ff[1]);
      m3_ff[1] <= MW'(pr_ff[2]) - MW'(pr_ff[3]);
      m3_ff[2] <= MW'(pr_ff[4]) - MW'(pr_ff[5]);
      d4_ff    <= d4_in;
      den4_ff  <= den4_in;
      for (int k = 0; k < 4; k++) begin
         ap5_ff[k] <= PW'(d4_ff[2*k]) * PW'(d4_ff[2*k+1]);
      end
      den5_ff  <= den4_ff;
      nu6_ff   <= MW'(ap5_ff[0]) - MW'(ap5_ff[1]);
      nv6_ff   <= MW'(ap5_ff[2]) - MW'(ap5_ff[3]);
      den6_ff  <= den5_ff;
      nmu_ff   <= nmu_in;
      nmv_ff   <= nmv_in;
      nmw_ff   <= nmw_in;
      dm_ff    <= dm_in;
      flags_ff <= flags_in;
   end

   assign out_valid  = v_ff[GEOM_STAGES-1];
   assign out_flags  = flags_ff;
   assign out_nmag_u = nmu_ff;
   assign out_nmag_v = nmv_ff;
   assign out_nmag_w = nmw_ff;
   assign out_dmag   = dm_ff;

endmodule

@@ hw/rtl/bpt_div.sv @@
// pipelined restoring divider, one quotient bit per stage, signed saturated Q2.F out
// depends on bpt_pkg
module bpt_div import bpt_pkg::*; #(
   parameter int NUM_BITS  = 2 * COORD_BITS_DEF + 7,
   parameter int FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic [NUM_BITS-1:0]         n_mag,
   input  logic [NUM_BITS-1:0]         d_mag,
   input  logic                        neg,
   output logic signed [FRAC_BITS+1:0] weight
);
   localparam int NW = NUM_BITS;
   localparam int QW = FRAC_BITS + 1;
   localparam int WW = FRAC_BITS + 2;
   localparam int NS = FRAC_BITS + 1;

   logic [NW-1:0] r_ff [NS], r_in [NS];
   logic [NW-1:0] d_ff [NS];
   logic [QW-1:0] q_ff [NS], q_in [NS];
   logic [NS-1:0] cap_ff, neg_ff;
   logic          cap_in, ge0;
   logic [NW:0]   r2 [NS];
   logic [NS-1:0] ge;
   logic signed [WW-1:0] weight_ff, weight_in;
   logic [WW-1:0] qv;

   always_comb begin
      // first step also flags quotients of two or more
      cap_in  = {1'b0, n_mag} >= {d_mag, 1'b0};
      ge0     = n_mag >= d_mag;
      r_in[0] = ge0 ? NW'(n_mag - d_mag) : n_mag;
      q_in[0] = QW'(ge0);
      r2[0]   = '0;
      ge[0]   = ge0;
      for (int k = 1; k < NS; k++) begin
         r2[k]   = {r_ff[k-1], 1'b0};
         ge[k]   = r2[k] >= {1'b0, d_ff[k-1]};
         r_in[k] = ge[k] ? NW'(r2[k] - {1'b0, d_ff[k-1]}) : NW'(r2[k]);
         q_in[k] = {q_ff[k-1][QW-2:0], ge[k]};
      end
   end

   always_comb begin
      qv = WW'(q_ff[NS-1]);
      if (cap_ff[NS-1]) begin
         weight_in = neg_ff[NS-1] ? {1'b1, {(WW-1){1'b0}}} : {1'b0, {(WW-1){1'b1}}};
      end else if (neg_ff[NS-1]) begin
         weight_in = -signed'(qv);
      end else begin
         weight_in = signed'(qv);
      end
   end

   always_ff @(posedge clock) begin
      r_ff[0]   <= r_in[0];
      q_ff[0]   <= q_in[0];
      d_ff[0]   <= d_mag;
      cap_ff[0] <= cap_in;
      neg_ff[0] <= neg;
      for (int k = 1; k < NS; k++) begin
         r_ff[k]   <= r_in[k];
         q_ff[k]   <= q_in[k];
         d_ff[k]   <= d_ff[k-1];
         cap_ff[k] <= cap_ff[k-1];
         neg_ff[k] <= neg_ff[k-1];
      end
      weight_ff <= weight_in;
   end

   assign weight = weight_ff;

endmodule

@@ hw/rtl/barycentric_point_in_triangle.sv @@
// top level of the barycentric point-in-triangle pipeline
// depends on bpt_pkg, bpt_geom and bpt_div
//
// channel   direction  handshake               payload
// req       in         start, busy             req_ax .. req_pz
// rsp       out        rsp_strobe              rsp_weight_u/v/w, rsp_inside_res, rsp_degenerate
//
// one item per cycle; busy is never raised
// the pipeline has 7 geometry stages plus WEIGHT_FRAC_BITS + 2 divider stages;
// the divider stage count is set by its one-bit-per-stage design
// synchronous reset clears only the valid bits; data registers are not reset
// results cannot be held off, so nothing in the pipeline ever stalls
module barycentric_point_in_triangle import bpt_pkg::*; #(
   parameter int COORD_BITS       = COORD_BITS_DEF,
   parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [COORD_BITS-1:0]       req_ax,
   input  logic signed [COORD_BITS-1:0]       req_ay,
   input  logic signed [COORD_BITS-1:0]       req_az,
   input  logic signed [COORD_BITS-1:0]       req_bx,
   input  logic signed [COORD_BITS-1:0]       req_by_coord,
   input  logic signed [COORD_BITS-1:0]       req_bz,
   input  logic signed [COORD_BITS-1:0]       req_cx,
   input  logic signed [COORD_BITS-1:0]       req_cy,
   input  logic signed [COORD_BITS-1:0]       req_cz,
   input  logic signed [COORD_BITS-1:0]       req_px,
   input  logic signed [COORD_BITS-1:0]       req_py,
   input  logic signed [COORD_BITS-1:0]       req_pz,
   output logic                               rsp_strobe,
   output logic signed [WEIGHT_FRAC_BITS+1:0] rsp_weight_u,
   output logic signed [WEIGHT_FRAC_BITS+1:0] rsp_weight_v,
   output logic signed [WEIGHT_FRAC_BITS+1:0] rsp_weight_w,
   output logic                               rsp_inside_res,
   output logic                               rsp_degenerate
);
   localparam int NW      = 2 * COORD_BITS + 7;
   localparam int WW      = WEIGHT_FRAC_BITS + 2;
   // divider: first step, one stage per fraction bit, output register
   localparam int DIV_LAT = WEIGHT_FRAC_BITS + 2;

   logic          g_valid;
   bpt_flags_type g_flags;
   logic [NW-1:0] g_nu, g_nv, g_nw, g_den;

   logic signed [WW-1:0] div_u, div_v, div_w;

   // valid bits and flags ride alongside the divider stages
   logic [DIV_LAT-1:0] dv_ff, dv_in;
   bpt_flags_type      df_ff [DIV_LAT], df_in [DIV_LAT];

   // fully pipelined, so an item can enter every cycle
   assign busy = 1'b0;

   bpt_geom #(
      .COORD_BITS (COORD_BITS)
   ) u_geom (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (start & ~busy),
      .ax         (req_ax),
      .ay         (req_ay),
      .az         (req_az),
      .bx         (req_bx),
      .by_coord   (req_by_coord),
      .bz         (req_bz),
      .cx         (req_cx),
      .cy         (req_cy),
      .cz         (req_cz),
      .px         (req_px),
      .py         (req_py),
      .pz         (req_pz),
      .out_valid  (g_valid),
      .out_flags  (g_flags),
      .out_nmag_u (g_nu),
      .out_nmag_v (g_nv),
      .out_nmag_w (g_nw),
      .out_dmag   (g_den)
   );

   // three weights divided in parallel lanes
   bpt_div #(.NUM_BITS(NW), .FRAC_BITS(WEIGHT_FRAC_BITS)) u_div_u (
      .clock (clock), .n_mag (g_nu), .d_mag (g_den), .neg (g_flags.neg_u), .weight (div_u)
   );
   bpt_div #(.NUM_BITS(NW), .FRAC_BITS(WEIGHT_FRAC_BITS)) u_div_v (
      .clock (clock), .n_mag (g_nv), .d_mag (g_den), .neg (g_flags.neg_v), .weight (div_v)
   );
   bpt_div #(.NUM_BITS(NW), .FRAC_BITS(WEIGHT_FRAC_BITS)) u_div_w (
      .clock (clock), .n_mag (g_nw), .d_mag (g_den), .neg (g_flags.neg_w), .weight (div_w)
   );

   always_comb begin
      dv_in    = {dv_ff[DIV_LAT-2:0], g_valid};
      df_in[0] = g_flags;
      for (int k = 1; k < DIV_LAT; k++) begin
         df_in[k] = df_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= '0;
      end else begin
         dv_ff <= dv_in;
      end
   end

   always_ff @(posedge clock) begin
      df_ff <= df_in;
   end

   // zero area: the divider output is meaningless, force weights to zero
   assign rsp_strobe     = dv_ff[DIV_LAT-1];
   assign rsp_degenerate = df_ff[DIV_LAT-1].degen;
   assign rsp_inside_res = df_ff[DIV_LAT-1].in_tri;
   assign rsp_weight_u   = df_ff[DIV_LAT-1].degen ? '0 : div_u;
   assign rsp_weight_v   = df_ff[DIV_LAT-1].degen ? '0 : div_v;
   assign rsp_weight_w   = df_ff[DIV_LAT-1].degen ? '0 : div_w;

`ifndef SYNTHESIS
   // every item leaving the geometry stages comes out after the divider
   a_lat: assert property (@(posedge clock) disable iff (reset)
      g_valid |-> ##DIV_LAT rsp_strobe)
      else $error("item lost in divider stages");

   // an inside point never gets a negative weight
   a_inside_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_inside_res |->
         !rsp_weight_u[WW-1] && !rsp_weight_v[WW-1] && !rsp_weight_w[WW-1])
      else $error("inside point with negative weight");

   // a degenerate triangle is never reported as containing the point
   a_degen: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_degenerate |-> !rsp_inside_res)
      else $error("degenerate triangle flagged inside");

   // no result without an item leaving the geometry stages at the matching earlier cycle
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(g_valid, DIV_LAT))
      else $error("result without an accepted item");
`endif

endmodule

@@ verif/tb_barycentric_point_in_triangle.sv @@
// self-checking testbench for the barycentric point-in-triangle pipeline
// depends on bpt_pkg and barycentric_point_in_triangle; directed table then random queries
`timescale 1ns / 100ps

module tb_barycentric_point_in_triangle;
   import bpt_pkg::*;

   localparam int CB = COORD_BITS_DEF;
   localparam int FB = WEIGHT_FRAC_BITS_DEF;
   localparam int WB = FB + 2;
   localparam int N_RANDOM = 550;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES = GEOM_STAGES + FB + 10;

   typedef logic signed [CB-1:0] coord_t;
   typedef logic signed [WB-1:0] weight_t;

   // one query: a, b, c, p (x, y, z each)
   typedef struct {
      coord_t c [12];
   } query_t;

   typedef struct {
      weight_t wu;
      weight_t wv;
      weight_t ww;
      logic    in_tri;
      logic    degen;
   } weights_t;

   // directed row: query plus an optional typed-in expectation
   typedef struct {
      query_t   q;
      bit       has_fixed;
      weights_t fixed;
   } dir_row_t;

   logic    clock = 0;
   logic    reset = 1;
   logic    start = 0;
   logic    busy;
   coord_t  req [12];
   logic    rsp_strobe;
   weight_t rsp_weight_u, rsp_weight_v, rsp_weight_w;
   logic    rsp_inside_res, rsp_degenerate;

   weights_t pending_weights [$];
   int       n_errors = 0;
   int       n_checked = 0;
   int       n_degen_seen = 0;
   int       n_inside_seen = 0;
   int       idle_count = 0;

   initial for (int i = 0; i < 12; i++) req[i] = '0;

   always #5 clock = ~clock;

   barycentric_point_in_triangle dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_ax(req[0]), .req_ay(req[1]), .req_az(req[2]),
      .req_bx(req[3]), .req_by_coord(req[4]), .req_bz(req[5]),
      .req_cx(req[6]), .req_cy(req[7]), .req_cz(req[8]),
      .req_px(req[9]), .req_py(req[10]), .req_pz(req[11]),
      .rsp_strobe(rsp_strobe),
      .rsp_weight_u(rsp_weight_u), .rsp_weight_v(rsp_weight_v),
      .rsp_weight_w(rsp_weight_w),
      .rsp_inside_res(rsp_inside_res), .rsp_degenerate(rsp_degenerate)
   );

   // truncated |n|/|d| in Q2.FB with saturation; d nonzero
   function automatic weight_t ratio_q2(longint n, longint d);
      longint unsigned mn, md, q, r;
      logic            neg;
      longint unsigned cap;
      cap = 64'd1 << (FB + 1);
      mn  = (n < 0) ? -n : n;
      md  = (d < 0) ? -d : d;
      neg = (n < 0) != (d < 0);
      q = mn / md;
      r = mn % md;
      if (q >= 2) q = cap;
      else begin
         for (int i = 0; i < FB; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= md) begin
               r = r - md;
               q = q | 1;
            end
         end
      end
      if (neg) return weight_t'(-q);
      return weight_t'((q >= cap) ? cap - 1 : q);
   endfunction

   function automatic bit sign_agrees(longint s, longint d);
      return s == 0 || ((s < 0) == (d < 0));
   endfunction

   function automatic longint tri_area(longint x1, longint y1, longint x2, longint y2,
                                       longint x3, longint y3);
      return (x1 - x2) * (y2 - y3) - (x2 - x3) * (y1 - y2);
   endfunction

   // project onto the plane of the dominant normal axis and form the weights
   function automatic weights_t barycentric_weights(query_t q);
      longint   a[3], b[3], c[3], p[3], e1[3], e2[3], m[3], am[3];
      longint   den, nu, nv, nw;
      int       s, t;
      weights_t r;
      for (int i = 0; i < 3; i++) begin
         a[i] = q.c[i]; b[i] = q.c[3+i]; c[i] = q.c[6+i]; p[i] = q.c[9+i];
         e1[i] = b[i] - a[i];
         e2[i] = c[i] - a[i];
      end
      m[0] = e1[1] * e2[2] - e1[2] * e2[1];
      m[1] = e1[2] * e2[0] - e1[0] * e2[2];
      m[2] = e1[0] * e2[1] - e1[1] * e2[0];
      for (int i = 0; i < 3; i++) am[i] = (m[i] < 0) ? -m[i] : m[i];
      // ties go to x, then y
      if (am[0] >= am[1] && am[0] >= am[2]) begin
         s = 1; t = 2; den = m[0];
      end else if (am[1] >= am[2]) begin
         s = 0; t = 2; den = -m[1];
      end else begin
         s = 0; t = 1; den = m[2];
      end
      r = '{default: '0};
      if (den == 0) begin
         r.degen = 1'b1;
         return r;
      end
      nu = tri_area(p[s], p[t], b[s], b[t], c[s], c[t]);
      nv = tri_area(p[s], p[t], c[s], c[t], a[s], a[t]);
      nw = den - nu - nv;
      r.wu = ratio_q2(nu, den);
      r.wv = ratio_q2(nv, den);
      r.ww = ratio_q2(nw, den);
      r.in_tri = sign_agrees(nu, den) && sign_agrees(nv, den) && sign_agrees(nw, den);
      return r;
   endfunction

   function automatic query_t make_query(int ax, int ay, int az, int bx, int by_, int bz,
                                         int cx, int cy, int cz, int px, int py, int pz);
      query_t q;
      q.c = '{coord_t'(ax), coord_t'(ay), coord_t'(az), coord_t'(bx), coord_t'(by_),
              coord_t'(bz), coord_t'(cx), coord_t'(cy), coord_t'(cz), coord_t'(px),
              coord_t'(py), coord_t'(pz)};
      return q;
   endfunction

   // issue one query after a random gap; start stays high for back-to-back items
   task automatic send_query(query_t q, weights_t exp_w, int max_gap);
      int gap;
      gap = $urandom_range(max_gap, 0);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      for (int i = 0; i < 12; i++) req[i] <= q.c[i];
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_weights.push_back(exp_w);
   endtask

   // drop start after the last item of a burst
   task automatic stop_sending();
      @(negedge clock);
      start <= 1'b0;
   endtask

   // result checker, sampled at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         weights_t e;
         if (pending_weights.size() == 0) begin
            $error("result with no query outstanding");
            n_errors++;
         end else begin
            e = pending_weights.pop_front();
            n_checked++;
            if (rsp_degenerate) n_degen_seen++;
            if (rsp_inside_res) n_inside_seen++;
            if (rsp_weight_u !== e.wu) begin
               $error("weight_u exp %0d got %0d", e.wu, rsp_weight_u); n_errors++;
            end
            if (rsp_weight_v !== e.wv) begin
               $error("weight_v exp %0d got %0d", e.wv, rsp_weight_v); n_errors++;
            end
            if (rsp_weight_w !== e.ww) begin
               $error("weight_w exp %0d got %0d", e.ww, rsp_weight_w); n_errors++;
            end
            if (rsp_inside_res !== e.in_tri) begin
               $error("inside_res exp %0b got %0b", e.in_tri, rsp_inside_res); n_errors++;
            end
            if (rsp_degenerate !== e.degen) begin
               $error("degenerate exp %0b got %0b", e.degen, rsp_degenerate); n_errors++;
            end
         end
      end
   end

   // watchdog: cycles with no item moving either way
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
         $display("watchdog: no activity for %0d cycles", WATCHDOG_LIMIT);
         $display("[barycentric_point_in_triangle] ERROR");
         $finish;
      end
   end

   function automatic coord_t rand_coord(int span);
      int v;
      v = $urandom_range(2 * span, 0);
      return coord_t'(v - span);
   endfunction

   localparam int MAXC = 32767;
   localparam int MINC = -32768;
   localparam weight_t ONE_Q = weight_t'(1 << FB);
   localparam weight_t SAT_POS = weight_t'((1 << (FB + 1)) - 1);
   localparam weight_t SAT_NEG = weight_t'(-(1 << (FB + 1)));

   dir_row_t dir_rows [$];

   initial begin
      query_t   q;
      weights_t e, z;
      dir_row_t row;
      int       kind, span, drained;

      z = '{default: '0};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      // all-zero coordinates: degenerate
      e = z; e.degen = 1;
      dir_rows.push_back('{make_query(0,0,0, 0,0,0, 0,0,0, 0,0,0), 1, e});
      // collinear extremes: degenerate
      dir_rows.push_back('{make_query(MINC,MINC,MINC, 0,0,0, MAXC,MAXC,MAXC,
                                      MAXC,MINC,MAXC), 1, e});
      // point at vertex a of an xy triangle
      e = z; e.wu = ONE_Q; e.in_tri = 1;
      dir_rows.push_back('{make_query(0,0,0, 10,0,0, 0,10,0, 0,0,5), 1, e});
      // point at vertex b
      e = z; e.wv = ONE_Q; e.in_tri = 1;
      dir_rows.push_back('{make_query(0,0,0, 10,0,0, 0,10,0, 10,0,-7), 1, e});
      // far point saturates both ways
      e = z; e.wu = SAT_NEG; e.wv = SAT_POS; e.ww = SAT_POS;
      dir_rows.push_back('{make_query(0,0,0, 1,0,0, 0,1,0, MAXC,MAXC,0), 1, e});
      // yz and xz planes, ties, extremes, edges, off-plane points
      dir_rows.push_back('{make_query(0,0,0, 0,10,0, 0,0,10, 99,3,3), 0, z});
      dir_rows.push_back('{make_query(0,0,0, 10,0,0, 0,0,10, 3,-50,3), 0, z});
      dir_rows.push_back('{make_query(0,0,0, 0,10,0, 0,0,10, 0,5,5), 0, z});
      dir_rows.push_back('{make_query(0,0,0, 1,1,0, 0,1,1, 0,1,0), 0, z});
      dir_rows.push_back('{make_query(0,0,0, 1,0,1, 0,1,1, 0,0,0), 0, z});
      dir_rows.push_back('{make_query(MINC,MINC,MINC, MAXC,MINC,MAXC, MINC,MAXC,MAXC,
                                      0,0,0), 0, z});
      dir_rows.push_back('{make_query(MAXC,MAXC,MAXC, MINC,MAXC,MINC, MAXC,MINC,MINC,
                                      MINC,MINC,MINC), 0, z});
      dir_rows.push_back('{make_query(MAXC,MINC,0, MINC,MAXC,0, MINC,MINC,MAXC,
                                      MAXC,MAXC,MINC), 0, z});
      dir_rows.push_back('{make_query(0,0,0, 10,0,0, 0,10,0, 5,5,0), 0, z});
      dir_rows.push_back('{make_query(0,0,0, 0,10,0, 10,0,0, 3,3,0), 0, z});
      dir_rows.push_back('{make_query(0,0,0, 3,0,0, 0,3,0, 1,1,0), 0, z});
      dir_rows.push_back('{make_query(-1,-1,-1, -1,-1,-1, -1,-1,-1, -1,-1,-1), 0, z});
      dir_rows.push_back('{make_query(0,0,0, 7,0,0, 0,7,0, -1,-1,0), 0, z});

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         send_query(row.q, row.has_fixed ? row.fixed : barycentric_weights(row.q), 2);
      end
      stop_sending();

      // let the pipeline drain once before the random part
      while (pending_weights.size() != 0) @(posedge clock);

      for (int n = 0; n < N_RANDOM; n++) begin
         kind = $urandom_range(9, 0);
         case (kind)
            0: begin
               // full-range noise
               for (int i = 0; i < 12; i++) q.c[i] = coord_t'($urandom);
            end
            1: begin
               // degenerate: c on line a-b, random p
               for (int i = 0; i < 6; i++) q.c[i] = rand_coord(1000);
               for (int i = 0; i < 3; i++) q.c[6+i] = coord_t'(2 * q.c[3+i] - q.c[i]);
               for (int i = 9; i < 12; i++) q.c[i] = coord_t'($urandom);
            end
            2: begin
               // tiny triangles, many ties and edge hits
               for (int i = 0; i < 12; i++) q.c[i] = rand_coord(3);
            end
            default: begin
               // point as a blend of the vertices, mostly inside
               span = (kind < 6) ? 200 : 16000;
               for (int i = 0; i < 9; i++) q.c[i] = rand_coord(span);
               for (int i = 0; i < 3; i++) begin
                  q.c[9+i] = coord_t'((longint'(q.c[i]) + q.c[3+i] + q.c[6+i]) / 3
                                      + $signed($urandom_range(4, 0)) - 2);
               end
            end
         endcase
         send_query(q, barycentric_weights(q), (n % 100 < 30) ? 0 : 6);
         // halfway through, hold off until every outstanding result has come
         if (n == N_RANDOM / 2) begin
            stop_sending();
            while (pending_weights.size() != 0) @(posedge clock);
         end
      end
      stop_sending();

      while (pending_weights.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d results: %0d degenerate, %0d inside", n_checked,
               n_degen_seen, n_inside_seen);
      if (n_errors == 0) $display("[barycentric_point_in_triangle] OK");
      else $display("[barycentric_point_in_triangle] ERROR");
      $finish;
   end

endmodule
